/* design/fcts_pkg.sv */
// Shared types and constants for the floor and ceiling texel span block.
`timescale 1ns / 1ps

package fcts_pkg;

  localparam int COORD_W    = 32;
  localparam int ROW_W      = 12;
  localparam int DIM_W      = 13;
  localparam int TEX_OUT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_TEX_WIDTH  = 64;
  localparam int DEF_TEX_HEIGHT = 64;

  localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = DIM_W'(480);

  // magnitudes of the saturation limits of signed Q16.16
  localparam logic [COORD_W-1:0] Q_MAX_MAG = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] Q_MIN_MAG = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH   = 3'd0,
    CFG_SCREEN_HEIGHT  = 3'd1,
    CFG_FLOOR_FLAT     = 3'd2,
    CFG_CEILING_FLAT   = 3'd3,
    CFG_FLOOR_COLOUR   = 3'd4,
    CFG_CEILING_COLOUR = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZFORM,
    ST_ZABS,
    ST_ZDIV,
    ST_DSAT,
    ST_BFORM,
    ST_BABS,
    ST_MUL,
    ST_WDIV,
    ST_FIN
  } setup_state_t;

  typedef struct packed {
    logic        [ROW_W-1:0]   row;
    logic signed [COORD_W-1:0] cam_pos_x;
    logic signed [COORD_W-1:0] cam_pos_y;
    logic signed [COORD_W-1:0] cam_height;
    logic signed [COORD_W-1:0] view_dir_x;
    logic signed [COORD_W-1:0] view_dir_y;
    logic signed [COORD_W-1:0] screen_plane_x;
    logic signed [COORD_W-1:0] screen_plane_y;
    logic        [DIM_W-1:0]   height;
    logic        [DIM_W-1:0]   width_eff;
  } row_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_y;
    logic [COORD_W-1:0] world_x;
    logic [COORD_W-1:0] world_y;
    logic [ROW_W-1:0]   row;
  } row_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } setup_status_t;

endpackage

/* design/fcts_row_setup.sv */
// Row-start engine: row distance, column step and start position on one shared adder.
`timescale 1ns / 1ps

module fcts_row_setup (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  fcts_pkg::row_req_t      req,
  output fcts_pkg::setup_status_t status,
  output fcts_pkg::row_res_t      res
);
  import fcts_pkg::*;

  localparam int ALU_W     = 66;
  localparam int WK_W      = 65;
  localparam int REM_W     = 14;
  localparam int DIV_STEPS = 64;
  localparam int MUL_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int HALF_W    = DIM_W - 1;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [1:0]       JOB_LAST = 2'd3;

  setup_state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       job, job_next;
  logic             done;

  row_req_t         req_q;
  logic [ROW_W-1:0] p;
  logic             row_above;
  logic [WK_W-1:0]  wk;
  logic [REM_W-1:0] rem;
  logic             zneg;
  logic             dneg;
  logic             bneg;
  logic [COORD_W-1:0] dm;

  logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_sub;

  logic [HALF_W-1:0]  half;
  logic [COORD_W-1:0] sel_plane, sel_dir, sel_pos, sat_val;
  logic               ovf_pos, ovf_neg;

  function automatic logic [ALU_W-1:0] sext32(input logic [COORD_W-1:0] v);
    return {{(ALU_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // the one adder shared by the forming, absolute value, divide, multiply and final steps
  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

  assign half      = req.height[DIM_W-1:1];
  assign sel_plane = job[0] ? req_q.screen_plane_y : req_q.screen_plane_x;
  assign sel_dir   = job[0] ? req_q.view_dir_y : req_q.view_dir_x;
  assign sel_pos   = job[0] ? req_q.cam_pos_y : req_q.cam_pos_x;

  assign ovf_pos = !alu_sum[ALU_W-1] && (alu_sum[ALU_W-2:COORD_W-1] != '0);
  assign ovf_neg = alu_sum[ALU_W-1] && (alu_sum[ALU_W-2:COORD_W-1] != '1);
  assign sat_val = ovf_pos ? Q_MAX_MAG : (ovf_neg ? Q_MIN_MAG : alu_sum[COORD_W-1:0]);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      ST_ZFORM: begin
        alu_a   = ALU_W'({req_q.height, 15'b0});
        alu_b   = sext32(req_q.cam_height);
        alu_sub = !row_above;
      end
      ST_ZABS, ST_BABS: begin
        alu_b   = {wk[WK_W-1], wk};
        alu_sub = 1'b1;
      end
      ST_ZDIV: begin
        alu_a   = ALU_W'({rem, wk[63]});
        alu_b   = ALU_W'(p);
        alu_sub = 1'b1;
      end
      ST_WDIV: begin
        alu_a   = ALU_W'({rem, wk[63]});
        alu_b   = ALU_W'(req_q.width_eff);
        alu_sub = 1'b1;
      end
      ST_BFORM: begin
        if (job[1]) begin
          alu_a   = sext32(sel_dir);
          alu_b   = sext32(sel_plane);
          alu_sub = 1'b1;
        end else begin
          alu_a = sext32(sel_plane) << 1;
        end
      end
      ST_MUL: begin
        alu_a = ALU_W'(wk[WK_W-1:33]);
        alu_b = wk[0] ? ALU_W'(dm) : '0;
      end
      ST_FIN: begin
        alu_a   = job[1] ? sext32(sel_pos) : '0;
        alu_b   = ALU_W'(wk[63:16]);
        alu_sub = dneg ^ bneg;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    job_next   = job;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ZFORM;
          job_next   = '0;
        end
      end
      ST_ZFORM: state_next = ST_ZABS;
      ST_ZABS: begin
        state_next = ST_ZDIV;
        cnt_next   = '0;
      end
      ST_ZDIV: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_DSAT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_DSAT:  state_next = ST_BFORM;
      ST_BFORM: state_next = ST_BABS;
      ST_BABS: begin
        state_next = ST_MUL;
        cnt_next   = '0;
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = job[1] ? ST_FIN : ST_WDIV;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_WDIV: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_FIN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_FIN: begin
        job_next   = job + 2'd1;
        state_next = (job == JOB_LAST) ? ST_IDLE : ST_BFORM;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      job  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      job  <= job_next;
      done <= (state == ST_FIN) && (job == JOB_LAST);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_q     <= req;
          row_above <= req.row > half;
          p         <= (req.row > half) ? (req.row - half) : (half - req.row);
        end
      end
      ST_ZFORM: wk <= alu_sum[WK_W-1:0];
      ST_ZABS: begin
        zneg <= wk[WK_W-1];
        if (wk[WK_W-1]) begin
          wk <= alu_sum[WK_W-1:0];
        end
        rem <= '0;
      end
      ST_ZDIV, ST_WDIV: begin
        // restoring step: trial subtract of the divisor from the shifted remainder
        if (!alu_sum[ALU_W-1]) begin
          rem       <= alu_sum[REM_W-1:0];
          wk[63:0]  <= {wk[62:0], 1'b1};
        end else begin
          rem       <= {rem[REM_W-2:0], wk[63]};
          wk[63:0]  <= {wk[62:0], 1'b0};
        end
      end
      ST_DSAT: begin
        dneg <= zneg;
        if (p == '0) begin
          dm <= zneg ? Q_MIN_MAG : Q_MAX_MAG;
        end else if (!zneg) begin
          dm <= (wk[63:0] > 64'(Q_MAX_MAG)) ? Q_MAX_MAG : wk[COORD_W-1:0];
        end else begin
          dm <= (wk[63:0] > 64'(Q_MIN_MAG)) ? Q_MIN_MAG : wk[COORD_W-1:0];
        end
      end
      ST_BFORM: wk <= alu_sum[WK_W-1:0];
      ST_BABS: begin
        // multiplier operand: high half clear, low half the magnitude
        bneg <= wk[WK_W-1];
        wk   <= {32'b0, (wk[WK_W-1] ? alu_sum[32:0] : wk[32:0])};
        rem  <= '0;
      end
      ST_MUL: wk <= {alu_sum[32:0], wk[32:1]};
      ST_FIN: begin
        unique case (job)
          2'd0: res.step_x  <= sat_val;
          2'd1: res.step_y  <= sat_val;
          2'd2: res.world_x <= sat_val;
          2'd3: res.world_y <= sat_val;
          default: res.world_y <= sat_val;
        endcase
        res.row <= req_q.row;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  assign status.busy = (state != ST_IDLE) || done;
  assign status.done = done;

endmodule

/* design/floor_ceiling_texel_span.sv */
// Top level: config registers, row start hand-off and per-column texel stepping.
// Row start (kind 0): once accepted, the block stays busy through row setup
//   (one 64-step division for the row distance, four 33-step multiplies and two
//   64-step divisions for the steps, all on the one shared adder in row setup).
// Column (kind 1): result sits in the output register next cycle,
//   one column per cycle while the output side keeps taking beats.
// Reset (rst, synchronous): no row active, output empty, width 640, height 480.
`timescale 1ns / 1ps

module floor_ceiling_texel_span #(
  parameter int TEX_WIDTH  = fcts_pkg::DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT = fcts_pkg::DEF_TEX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write port
  input  logic                                 cfg_write,
  input  logic [fcts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcts_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input beats
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic [fcts_pkg::ROW_W-1:0]           row,
  input  logic signed [fcts_pkg::COORD_W-1:0]  cam_pos_x,
  input  logic signed [fcts_pkg::COORD_W-1:0]  cam_pos_y,
  input  logic signed [fcts_pkg::COORD_W-1:0]  cam_height,
  input  logic signed [fcts_pkg::COORD_W-1:0]  view_dir_x,
  input  logic signed [fcts_pkg::COORD_W-1:0]  view_dir_y,
  input  logic signed [fcts_pkg::COORD_W-1:0]  screen_plane_x,
  input  logic signed [fcts_pkg::COORD_W-1:0]  screen_plane_y,
  // result beats
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fcts_pkg::ROW_W-1:0]           column,
  output logic [fcts_pkg::ROW_W-1:0]           floor_row,
  output logic [fcts_pkg::ROW_W-1:0]           ceiling_row,
  output logic [fcts_pkg::TEX_OUT_W-1:0]       tex_u,
  output logic [fcts_pkg::TEX_OUT_W-1:0]       tex_v,
  output logic                                 last_in_row
);
  import fcts_pkg::*;

  // config; flat selects and colours belong to the downstream shader, so
  // those writes are taken and dropped here
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [DIM_W-1:0] width_eff;

  // column stepping state
  logic [COORD_W-1:0] world_x, world_y, step_x, step_y;
  logic [DIM_W-1:0]   next_column;
  logic [ROW_W-1:0]   active_row;
  logic               row_running;

  row_req_t      setup_req;
  row_res_t      setup_res;
  setup_status_t setup_st;

  logic row_fire, col_fire, col_emit, col_last;

  // texel from the fraction of a world coordinate, truncated toward zero
  function automatic logic [TEX_OUT_W-1:0] texel(input logic [COORD_W-1:0] w,
                                                 input logic [COORD_W-1:0] tex);
    logic [15:0] frac;
    logic [31:0] prod;
    logic [15:0] t;
    frac = w[COORD_W-1] ? (16'd0 - w[15:0]) : w[15:0];
    prod = {16'b0, frac} * tex;
    t    = prod[31:16];
    if (w[COORD_W-1]) begin
      t = 16'd0 - t;
    end
    return t[TEX_OUT_W-1:0] & TEX_OUT_W'(tex - 32'd1);
  endfunction

  assign width_eff = (screen_width == '0) ? DIM_W'(1) : screen_width;

  // new beats only when setup is quiet and the output register has room
  assign in_ready = !setup_st.busy && (!out_valid || out_ready);
  assign row_fire = in_valid && in_ready && !kind;
  assign col_fire = in_valid && in_ready && kind;
  assign col_emit = col_fire && row_running;
  assign col_last = ({1'b0, next_column} + 14'd1) >= {1'b0, width_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_WIDTH:   screen_width  <= cfg_data[DIM_W-1:0];
        CFG_SCREEN_HEIGHT:  screen_height <= cfg_data[DIM_W-1:0];
        CFG_FLOOR_FLAT:     screen_width  <= screen_width;
        CFG_CEILING_FLAT:   screen_width  <= screen_width;
        CFG_FLOOR_COLOUR:   screen_width  <= screen_width;
        CFG_CEILING_COLOUR: screen_width  <= screen_width;
        default:            screen_width  <= screen_width;
      endcase
    end
  end

  always_comb begin
    setup_req.row            = row;
    setup_req.cam_pos_x      = cam_pos_x;
    setup_req.cam_pos_y      = cam_pos_y;
    setup_req.cam_height     = cam_height;
    setup_req.view_dir_x     = view_dir_x;
    setup_req.view_dir_y     = view_dir_y;
    setup_req.screen_plane_x = screen_plane_x;
    setup_req.screen_plane_y = screen_plane_y;
    setup_req.height         = screen_height;
    setup_req.width_eff      = width_eff;
  end

  fcts_row_setup u_setup (
    .clk    (clk),
    .rst    (rst),
    .start  (row_fire),
    .req    (setup_req),
    .status (setup_st),
    .res    (setup_res)
  );

  // row state: loaded when setup finishes, advanced by each column beat of a running row
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      row_running <= 1'b0;
      next_column <= '0;
      active_row  <= '0;
      world_x     <= '0;
      world_y     <= '0;
      step_x      <= '0;
      step_y      <= '0;
    end else begin
      if (col_emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (setup_st.done) begin
        world_x     <= setup_res.world_x;
        world_y     <= setup_res.world_y;
        step_x      <= setup_res.step_x;
        step_y      <= setup_res.step_y;
        active_row  <= setup_res.row;
        next_column <= '0;
        row_running <= 1'b1;
      end else if (col_emit) begin
        world_x   <= world_x + step_x;
        world_y   <= world_y + step_y;
        if (col_last) begin
          row_running <= 1'b0;
          next_column <= '0;
        end else begin
          next_column <= next_column + DIM_W'(1);
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (col_emit) begin
      column      <= next_column[ROW_W-1:0];
      floor_row   <= active_row;
      ceiling_row <= screen_height[ROW_W-1:0] - active_row - ROW_W'(1);
      tex_u       <= texel(world_x, 32'(TEX_WIDTH));
      tex_v       <= texel(world_y, 32'(TEX_HEIGHT));
      last_in_row <= col_last;
    end
  end

  // a row start always hands over to setup for the next cycle
  a_row_start_busy: assert property (@(posedge clk) disable iff (rst)
    row_fire |=> !in_ready)
    else $error("input taken right after a row start");

  // the final column of a row closes it
  a_last_closes_row: assert property (@(posedge clk) disable iff (rst)
    (col_emit && col_last) |=> !row_running)
    else $error("row still running after its last column");

  // setup finish opens the row exactly once
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    setup_st.done |=> (!setup_st.done && row_running))
    else $error("setup done not a single pulse into a running row");

endmodule
